>>> sv/column_statistics_defines.svh
// ----------------------------------------------------------------------------
// column_statistics_defines: assertion macros for the column statistics block
// ----------------------------------------------------------------------------
`ifndef COLUMN_STATISTICS_DEFINES_SVH
`define COLUMN_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define CS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("column_statistics check failed");

// Next-cycle implication
`define CS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("column_statistics check failed");

`endif

>>> sv/cs_pkg.sv
// ----------------------------------------------------------------------------
// cs_pkg: shared types and constants of the column statistics block
// Payload structs, operation codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam int SMP_W  = 24;  // Q12.12 sample
    localparam int VAL_W  = 30;  // Q18.12 result
    localparam int IDX_W  = 6;
    localparam int DIV_W  = 56;  // dividend / quotient width
    localparam int DVS_W  = 25;  // divisor width
    localparam int SQ_W   = 50;  // one squared deviation
    localparam int RT_W   = 28;  // square root width
    localparam int FRAC_W = 12;

    localparam logic [2:0] OP_SUM  = 3'd0;
    localparam logic [2:0] OP_MEAN = 3'd1;
    localparam logic [2:0] OP_SD   = 3'd2;
    localparam logic [2:0] OP_DEV  = 3'd3;
    localparam logic [2:0] OP_Z    = 3'd4;
    localparam logic [2:0] OP_MAX  = 3'd5;
    localparam logic [2:0] OP_MIN  = 3'd6;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    sample_missing;
        logic                    last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    undefined;
        logic                    overflowed;
        logic [IDX_W-1:0]        result_index;
        logic                    last_result;
    } out_item_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_en;
        logic mean_start;
        logic mean_take;
        logic ss_clear;
        logic idx_clear;
        logic idx_inc;
        logic rd;
        logic diff_take;
        logic sq_take;
        logic ss_acc;
        logic var_start;
        logic sqrt_start;
        logic z_start;
        logic emit_red;
        logic emit_smp;
        logic clear_col;
    } cs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_in;
        logic n_zero;
        logic per_sample;
        logic need_ss;
        logic z_needed;
        logic idx_last;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } cs_stat_t;

endpackage

>>> sv/cs_ram.sv
// ----------------------------------------------------------------------------
// cs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/cs_ctrl.sv
// ----------------------------------------------------------------------------
// cs_ctrl: sequencer of the column statistics block
// Loads samples, then steps the datapath through mean, variance and square
// root (these two only for standard deviation and z-score) and the result walk.
// ----------------------------------------------------------------------------
module cs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  cs_pkg::cs_stat_t stat,
    output cs_pkg::cs_cmd_t  cmd
);
    import cs_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_MEAN_START, S_MEAN_WAIT, S_SS_RD, S_SS_DIFF, S_SS_MUL,
        S_SS_ACC, S_VAR_START, S_VAR_WAIT, S_SQRT_WAIT, S_PICK, S_RED_OUT,
        S_SMP_RD, S_SMP_DIFF, S_Z_START, S_Z_WAIT, S_SMP_OUT, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (stat.last_in)
                begin
                    state_next = S_MEAN_START;
                end
            end
            S_MEAN_START:
            begin
                cmd.mean_start = 1'b1;
                state_next     = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mean_take = 1'b1;
                    cmd.ss_clear  = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = stat.need_ss ? S_SS_RD : S_PICK;
                end
            end
            S_SS_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SS_DIFF;
            end
            S_SS_DIFF:
            begin
                cmd.diff_take = 1'b1;
                state_next    = S_SS_MUL;
            end
            S_SS_MUL:
            begin
                cmd.sq_take = 1'b1;
                state_next  = S_SS_ACC;
            end
            S_SS_ACC:
            begin
                cmd.ss_acc  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = stat.idx_last ? S_VAR_START : S_SS_RD;
            end
            S_VAR_START:
            begin
                cmd.var_start = 1'b1;
                state_next    = S_VAR_WAIT;
            end
            S_VAR_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (!stat.sqrt_busy)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.idx_clear = 1'b1;
                priority if (!stat.per_sample)
                begin
                    state_next = S_RED_OUT;
                end
                else if (stat.n_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SMP_RD;
                end
            end
            S_RED_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_red = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_SMP_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SMP_DIFF;
            end
            S_SMP_DIFF:
            begin
                cmd.diff_take = 1'b1;
                state_next    = stat.z_needed ? S_Z_START : S_SMP_OUT;
            end
            S_Z_START:
            begin
                cmd.z_start = 1'b1;
                state_next  = S_Z_WAIT;
            end
            S_Z_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SMP_OUT;
                end
            end
            S_SMP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_smp = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = stat.idx_last ? S_FINISH : S_SMP_RD;
                end
            end
            S_FINISH:
            begin
                cmd.clear_col = 1'b1;
                state_next    = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

>>> sv/cs_dp.sv
// ----------------------------------------------------------------------------
// cs_dp: datapath of the column statistics block
// Column accumulators, sample store, shared restoring divider, bit-pair
// square root and the result register.
// ----------------------------------------------------------------------------
module cs_dp #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cs_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cs_pkg::out_item_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data,
    input  cs_pkg::cs_cmd_t   cmd,
    output cs_pkg::cs_stat_t  stat
);
    import cs_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((64'd1 << (VAL_W - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'd1 << (VAL_W - 1));

    // Configuration and column state
    logic [2:0]              op_reg;
    logic [CW-1:0]           count_reg;
    logic signed [VAL_W-1:0] sum_reg;
    logic signed [SMP_W-1:0] ext_reg;
    logic                    anydef_reg, anymiss_reg, ovf_reg, sddef_reg;

    logic in_xfer, store_we;
    logic signed [SMP_W-1:0] x;

    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && cmd.load_en;
    assign x         = in_data.sample;
    assign store_we  = in_xfer && (count_reg < CW'(MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_MEAN;
        end
        else if (cfg_valid)
        begin
            op_reg <= cfg_data;
        end
    end

    // Accumulate on each loaded sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            ext_reg     <= '0;
            anydef_reg  <= 1'b0;
            anymiss_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.clear_col)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            ext_reg     <= '0;
            anydef_reg  <= 1'b0;
            anymiss_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (store_we)
            begin
                count_reg <= count_reg + CW'(1);
                if (in_data.sample_missing)
                begin
                    anymiss_reg <= 1'b1;
                end
                else
                begin
                    sum_reg    <= sum_reg + VAL_W'(x);
                    anydef_reg <= 1'b1;
                    priority if (!anydef_reg)
                    begin
                        ext_reg <= x;
                    end
                    else if (op_reg == OP_MIN)
                    begin
                        if (x < ext_reg) ext_reg <= x;
                    end
                    else
                    begin
                        if (x > ext_reg) ext_reg <= x;
                    end
                end
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Sample store
    logic [AW-1:0]    idx_reg;
    logic [SMP_W-1:0] rdata;

    cs_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SAMPLES)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_data.sample),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    logic [DIV_W-1:0] div_q_reg;
    logic [DVS_W:0]   div_r_reg;
    logic [DVS_W-1:0] div_d_reg;
    logic [5:0]       div_cnt_reg;
    logic             div_busy_reg;
    logic [DVS_W+1:0] div_rsh, div_diff;
    logic             div_ge;
    logic [VAL_W-1:0] sum_abs;

    logic signed [DVS_W-1:0] mean_reg, d_reg;
    logic [DVS_W-1:0]        ad;
    logic [DIV_W-1:0]        ss_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DVS_W-1:0]        n_dvs;
    logic [DVS_W-1:0]        sd;

    // Magnitude of the sum, unsigned so the most negative sum stays exact
    assign sum_abs  = (sum_reg < 0) ? VAL_W'(-sum_reg) : VAL_W'(sum_reg);
    assign n_dvs    = DVS_W'(count_reg);
    assign div_rsh  = {div_r_reg, div_q_reg[DIV_W-1]};
    assign div_diff = div_rsh - {2'b00, div_d_reg};
    assign div_ge   = div_rsh >= {2'b00, div_d_reg};
    assign ad       = (d_reg < 0) ? DVS_W'(-d_reg) : DVS_W'(d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.mean_start || cmd.var_start || cmd.z_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 6'(DIV_W - 1);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
            if (div_cnt_reg == 6'd0)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_start)
        begin
            div_q_reg <= DIV_W'(sum_abs);
            div_r_reg <= '0;
            div_d_reg <= stat.n_zero ? DVS_W'(1) : n_dvs;
        end
        else if (cmd.var_start)
        begin
            div_q_reg <= ss_reg;
            div_r_reg <= '0;
            div_d_reg <= n_dvs - DVS_W'(1);
        end
        else if (cmd.z_start)
        begin
            div_q_reg <= DIV_W'(ad) << FRAC_W;
            div_r_reg <= '0;
            div_d_reg <= sd;
        end
        else if (div_busy_reg)
        begin
            div_q_reg <= {div_q_reg[DIV_W-2:0], div_ge};
            div_r_reg <= div_ge ? div_diff[DVS_W:0] : div_rsh[DVS_W:0];
        end
    end

    // Mean, deviation and squared-deviation sum
    always_ff @(posedge clk)
    begin
        if (cmd.mean_take)
        begin
            mean_reg <= (sum_reg < 0) ? -$signed(div_q_reg[DVS_W-1:0])
                                      : $signed(div_q_reg[DVS_W-1:0]);
        end
        if (cmd.diff_take)
        begin
            d_reg <= DVS_W'({{2{rdata[SMP_W-1]}}, rdata} - {mean_reg[DVS_W-1], mean_reg});
        end
        if (cmd.sq_take)
        begin
            sq_reg <= ad * ad;
        end
        if (cmd.ss_clear)
        begin
            ss_reg <= '0;
        end
        else if (cmd.ss_acc)
        begin
            ss_reg <= ss_reg + DIV_W'(sq_reg);
        end
    end

    // Bit-pair square root of the variance
    logic [DIV_W-1:0] sq_x_reg;
    logic [RT_W+1:0]  sq_rem_reg;
    logic [RT_W-1:0]  sq_root_reg;
    logic [4:0]       sq_cnt_reg;
    logic             sq_busy_reg;
    logic [RT_W+3:0]  sq_rsh, sq_trial;
    logic             sq_ge;

    assign sq_rsh   = {sq_rem_reg, sq_x_reg[DIV_W-1 -: 2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = sq_rsh >= sq_trial;
    assign sd       = sq_root_reg[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
            sddef_reg   <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= 5'(RT_W - 1);
            sddef_reg   <= 1'b1;
        end
        else
        begin
            if (cmd.clear_col)
            begin
                sddef_reg <= 1'b0;
            end
            if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == 5'd0)
                begin
                    sq_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_x_reg    <= div_q_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_x_reg    <= sq_x_reg << 2;
            sq_rem_reg  <= sq_ge ? (RT_W+2)'(sq_rsh - sq_trial) : (RT_W+2)'(sq_rsh);
            sq_root_reg <= {sq_root_reg[RT_W-2:0], sq_ge};
        end
    end

    // Result selection
    logic                    n_gt1, idx_last, zero_sd;
    logic signed [VAL_W-1:0] z_val, red_val, smp_val;
    logic                    red_undef, smp_undef;

    assign n_gt1    = count_reg > CW'(1);
    assign idx_last = CW'(idx_reg) == (count_reg - CW'(1));
    assign zero_sd  = (sd == '0);

    always_comb
    begin
        if (d_reg < 0)
        begin
            z_val = (div_q_reg > NEG_LIM) ? -$signed(NEG_LIM[VAL_W-1:0])
                                          : -$signed(div_q_reg[VAL_W-1:0]);
        end
        else
        begin
            z_val = (div_q_reg > POS_LIM) ? $signed(POS_LIM[VAL_W-1:0])
                                          : $signed(div_q_reg[VAL_W-1:0]);
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_SUM:
            begin
                red_val   = sum_reg;
                red_undef = anymiss_reg || stat.n_zero;
            end
            OP_MEAN:
            begin
                red_val   = VAL_W'(mean_reg);
                red_undef = anymiss_reg || stat.n_zero;
            end
            OP_SD:
            begin
                red_val   = VAL_W'(sd);
                red_undef = anymiss_reg || !sddef_reg;
            end
            OP_MAX, OP_MIN:
            begin
                red_val   = VAL_W'(ext_reg);
                red_undef = !anydef_reg;
            end
            default:
            begin
                red_val   = '0;
                red_undef = 1'b1;
            end
        endcase
    end

    assign smp_undef = anymiss_reg || ((op_reg == OP_Z) && (!sddef_reg || zero_sd));
    assign smp_val   = (op_reg == OP_Z) ? z_val : VAL_W'(d_reg);

    // Result register
    logic      out_valid_reg;
    out_item_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_red || cmd.emit_smp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_red)
        begin
            out_reg.value        <= red_undef ? '0 : red_val;
            out_reg.undefined    <= red_undef;
            out_reg.overflowed   <= ovf_reg;
            out_reg.result_index <= '0;
            out_reg.last_result  <= 1'b1;
        end
        else if (cmd.emit_smp)
        begin
            out_reg.value        <= smp_undef ? '0 : smp_val;
            out_reg.undefined    <= smp_undef;
            out_reg.overflowed   <= ovf_reg;
            out_reg.result_index <= IDX_W'(idx_reg);
            out_reg.last_result  <= idx_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status to the controller
    assign stat.last_in    = in_xfer && in_data.last_sample;
    assign stat.n_zero     = (count_reg == '0);
    assign stat.per_sample = (op_reg == OP_DEV) || (op_reg == OP_Z);
    assign stat.need_ss    = ((op_reg == OP_SD) || (op_reg == OP_Z)) && n_gt1;
    assign stat.z_needed   = (op_reg == OP_Z) && !anymiss_reg && sddef_reg && !zero_sd;
    assign stat.idx_last   = idx_last;
    assign stat.div_busy   = div_busy_reg;
    assign stat.sqrt_busy  = sq_busy_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

>>> sv/column_statistics.sv
// ----------------------------------------------------------------------------
// column_statistics: one-column statistics unit
// Sum, mean, standard deviation, deviation, z-score, maximum and minimum of
// one stored column of Q12.12 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a column loads; the sample marked
// last starts the run and input stalls until its final result transfer is
// accepted into the output register. With the output free, a reduction run
// takes one pass of the shared divider for the mean, then picks, emits and
// finishes. Standard deviation and z-score then read, square and accumulate
// the deviation of each stored sample, pass the sum through the divider for
// the variance and take its square root; z-score then takes a divider pass
// per sample, deviation reads each sample and emits its deviation. The store
// is not cleared after reset; only entries of the current column are read.
module column_statistics #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cs_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cs_pkg::out_item_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data
);
    import cs_pkg::*;

`include "column_statistics_defines.svh"

    cs_cmd_t  cmd;
    cs_stat_t stat;

    assign in_stall = !cmd.load_en;

    cs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    cs_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // An undefined result carries a zero value
    `CS_ASSERT_NOW(a_undef_zero, out_valid && out_data.undefined, out_data.value == '0)
    // Input stops after the last sample of a column
    `CS_ASSERT_NEXT(a_stop_after_last, in_valid && !in_stall && in_data.last_sample, in_stall)
    // Results other than the last one appear only while input is held
    `CS_ASSERT_NOW(a_mid_run_stall, out_valid && !out_data.last_result, in_stall)

endmodule
